// ===== rtl/core/lzss_pkg.sv =====
// Shared constants for the LZSS window decompressor.
`default_nettype none

package lzss_pkg;

  localparam int unsigned WinAw    = 12;
  localparam int unsigned WinDepth = 4096;
  localparam int unsigned CntW     = 17;
  localparam int unsigned RunW     = 5;

  // parse phase codes
  localparam logic [1:0] PH_FLAG = 2'd0;
  localparam logic [1:0] PH_ITEM = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/core/lzss_window_decompressor_top.sv =====
// LZSS decompressor with a 4096-byte history window, top level.
`default_nettype none

// LZSS decompressor, 4 KiB window. Compressed bytes arrive on the input
// channel one transfer at a time; decompressed bytes and the end-of-chunk
// result leave on the output channel. After reset the block zeroes the
// history window (one entry per cycle) and holds in_ready_o low while it
// does so. A flag byte, token low byte, literal or ignored byte is then
// accepted whenever the output register is free. A match token's high
// byte starts a copy of 2 to 17 bytes, during which in_ready_o is low:
// each byte is a window read followed, once the output register is free,
// by the registered read data being written back at the write pointer and
// loaded into the output register. Because the write lands before the
// next read is issued, copies that overlap the bytes they are writing
// need no forwarding. Asserting chunk_start_i with a byte restarts the
// parse; the window keeps its contents across chunks.
module lzss_window_decompressor_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        chunk_start_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             byte_valid_o,
  output logic             run_last_o,
  output logic             chunk_done_o,
  output logic [16:0]      produced_count_o
);
  import lzss_pkg::*;

  // sequencer states
  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_WR   = 2'd3;

  localparam logic [CntW-1:0]  CntMax  = CntW'(WinDepth) << 4;
  localparam logic [WinAw-1:0] AddrTop = WinAw'(WinDepth - 1);

  logic [1:0]       state_q, state_d;
  logic [WinAw-1:0] clr_q, clr_d;
  logic [WinAw-1:0] wp_q, wp_d;
  logic [7:0]       flags_q, flags_d;
  logic [2:0]       fpos_q, fpos_d;
  logic [1:0]       phase_q, phase_d;
  logic [7:0]       tlow_q, tlow_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WinAw-1:0] pos_q, pos_d;
  logic [RunW-1:0]  rem_q, rem_d;

  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             byte_valid_q, byte_valid_d;
  logic             run_last_q, run_last_d;
  logic             chunk_done_q, chunk_done_d;
  logic [CntW-1:0]  count_q, count_d;

  // window memory
  logic [7:0]       mem [WinDepth];
  logic             mem_we, mem_re;
  logic [WinAw-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata, rdata_q;

  logic             out_free, in_xfer, out_load;
  logic [1:0]       eff_phase;
  logic [WinAw-1:0] eff_wp;
  logic [CntW-1:0]  eff_cnt;
  logic [2:0]       eff_fpos;
  logic [WinAw-1:0] tok_pos;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  // chunk start overrides the parse state seen by this byte
  assign eff_phase = chunk_start_i ? PH_FLAG : phase_q;
  assign eff_wp    = chunk_start_i ? WinAw'(1) : wp_q;
  assign eff_cnt   = chunk_start_i ? '0 : cnt_q;
  assign eff_fpos  = chunk_start_i ? 3'd0 : fpos_q;
  assign tok_pos   = {in_byte_i, tlow_q[7:4]};

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    wp_d         = wp_q;
    flags_d      = flags_q;
    fpos_d       = fpos_q;
    phase_d      = phase_q;
    tlow_d       = tlow_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    rem_d        = rem_q;
    out_load     = 1'b0;
    out_byte_d   = out_byte_q;
    byte_valid_d = byte_valid_q;
    run_last_d   = run_last_q;
    chunk_done_d = chunk_done_q;
    count_d      = count_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = wp_q;
    mem_wdata    = rdata_q;
    mem_raddr    = pos_q;

    case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = 8'h00;
        clr_d     = clr_q + WinAw'(1);
        if (clr_q == AddrTop) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          wp_d    = eff_wp;
          cnt_d   = eff_cnt;
          fpos_d  = eff_fpos;
          if (chunk_start_i) begin
            tlow_d = 8'h00;
          end
          case (eff_phase)
            PH_FLAG: begin
              flags_d = in_byte_i;
              fpos_d  = 3'd0;
              phase_d = PH_ITEM;
            end
            PH_ITEM: begin
              if (!flags_q[eff_fpos]) begin
                // literal
                mem_we       = 1'b1;
                mem_waddr    = eff_wp;
                mem_wdata    = in_byte_i;
                wp_d         = eff_wp + WinAw'(1);
                cnt_d        = (eff_cnt == CntMax) ? eff_cnt : eff_cnt + CntW'(1);
                out_load     = 1'b1;
                out_byte_d   = in_byte_i;
                byte_valid_d = 1'b1;
                run_last_d   = 1'b1;
                chunk_done_d = 1'b0;
                count_d      = '0;
                fpos_d       = eff_fpos + 3'd1;
                phase_d      = (eff_fpos == 3'd7) ? PH_FLAG : PH_ITEM;
              end else begin
                tlow_d  = in_byte_i;
                phase_d = PH_HIGH;
              end
            end
            PH_HIGH: begin
              if (tok_pos == '0) begin
                out_load     = 1'b1;
                out_byte_d   = 8'h00;
                byte_valid_d = 1'b0;
                run_last_d   = 1'b1;
                chunk_done_d = 1'b1;
                count_d      = eff_cnt;
                phase_d      = PH_DONE;
              end else begin
                pos_d   = tok_pos;
                rem_d   = {1'b0, tlow_q[3:0]} + RunW'(2);
                fpos_d  = eff_fpos + 3'd1;
                phase_d = (eff_fpos == 3'd7) ? PH_FLAG : PH_ITEM;
                state_d = S_RD;
              end
            end
            default: begin
              // chunk finished: byte dropped
            end
          endcase
        end
      end
      S_RD: begin
        mem_re  = 1'b1;
        state_d = S_WR;
      end
      default: begin
        // S_WR: read data ready, write back and emit
        if (out_free) begin
          mem_we       = 1'b1;
          wp_d         = wp_q + WinAw'(1);
          cnt_d        = (cnt_q == CntMax) ? cnt_q : cnt_q + CntW'(1);
          out_load     = 1'b1;
          out_byte_d   = rdata_q;
          byte_valid_d = 1'b1;
          run_last_d   = (rem_q == RunW'(1));
          chunk_done_d = 1'b0;
          count_d      = '0;
          pos_d        = pos_q + WinAw'(1);
          rem_d        = rem_q - RunW'(1);
          state_d      = (rem_q == RunW'(1)) ? S_IDLE : S_RD;
        end
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      wp_q        <= WinAw'(1);
      flags_q     <= 8'h00;
      fpos_q      <= 3'd0;
      phase_q     <= PH_FLAG;
      tlow_q      <= 8'h00;
      cnt_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      wp_q        <= wp_d;
      flags_q     <= flags_d;
      fpos_q      <= fpos_d;
      phase_q     <= phase_d;
      tlow_q      <= tlow_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    out_byte_q   <= out_byte_d;
    byte_valid_q <= byte_valid_d;
    run_last_q   <= run_last_d;
    chunk_done_q <= chunk_done_d;
    count_q      <= count_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign byte_valid_o     = byte_valid_q;
  assign run_last_o       = run_last_q;
  assign chunk_done_o     = chunk_done_q;
  assign produced_count_o = count_q;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for the LZSS window decompressor: scoreboard, stimulus and checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lzss_pkg::*;

  // Saturation point of the per-chunk output byte count.
  localparam logic [CntW-1:0] COUNT_LIMIT = 17'd65536;
  // Latency allowance after the last expected result: one full 17-byte copy and margin.
  localparam int unsigned TAIL_CYCLES = 60;
  // Items in the random part (ignored bytes after an end token are not counted).
  localparam int unsigned RANDOM_ITEMS = 100;

  typedef struct packed {
    logic [7:0]      out_byte;
    logic            byte_valid;
    logic            run_last;
    logic            chunk_done;
    logic [CntW-1:0] produced_count;
  } dec_result_t;

  // Mirrors the decompressor: own window, pointer and parse state. Every
  // accepted input transfer is decoded here into the results it must cause.
  class lzss_scoreboard;
    logic [7:0]       window_mem [WinDepth];
    logic [WinAw-1:0] wr_ptr;
    logic [7:0]       flag_bits;
    int unsigned      flag_pos;
    logic [1:0]       phase;
    logic [7:0]       tok_low;
    logic [CntW-1:0]  emitted;
    dec_result_t      pending_q [$];
    int unsigned      errors;
    int unsigned      seen;

    function new();
      foreach (window_mem[i]) window_mem[i] = 8'h00;
      wr_ptr    = 1;
      flag_bits = '0;
      flag_pos  = 0;
      phase     = PH_FLAG;
      tok_low   = '0;
      emitted   = '0;
      errors    = 0;
      seen      = 0;
    endfunction

    task report(input string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    function void push_byte(input logic [7:0] b);
      dec_result_t r;
      window_mem[wr_ptr] = b;
      wr_ptr = wr_ptr + 1'b1;
      if (emitted < COUNT_LIMIT) emitted = emitted + 1'b1;
      r = '0;
      r.out_byte   = b;
      r.byte_valid = 1'b1;
      pending_q.insert(pending_q.size(), r);
    endfunction

    function void step_flag();
      flag_pos++;
      if (flag_pos >= 8) begin
        flag_pos = 0;
        phase    = PH_FLAG;
      end else begin
        phase = PH_ITEM;
      end
    endfunction

    // Decode one accepted compressed byte.
    function void note_input(input logic [7:0] b, input logic start);
      logic [15:0]      tok;
      logic [WinAw-1:0] rd_pos;
      int unsigned      run_len;
      int unsigned      old_size;
      dec_result_t      r;
      old_size = pending_q.size();
      if (start) begin
        wr_ptr    = 1;
        flag_bits = '0;
        flag_pos  = 0;
        tok_low   = '0;
        emitted   = '0;
        phase     = PH_FLAG;
      end
      case (phase)
        PH_FLAG: begin
          flag_bits = b;
          flag_pos  = 0;
          phase     = PH_ITEM;
        end
        PH_ITEM: begin
          if (!flag_bits[flag_pos]) begin
            push_byte(b);
            step_flag();
          end else begin
            tok_low = b;
            phase   = PH_HIGH;
          end
        end
        PH_HIGH: begin
          tok    = {b, tok_low};
          rd_pos = tok[15:4];
          if (rd_pos == '0) begin
            r = '0;
            r.chunk_done     = 1'b1;
            r.produced_count = emitted;
            pending_q.insert(pending_q.size(), r);
            phase = PH_DONE;
          end else begin
            run_len = int'(tok[3:0]) + 2;
            for (int i = 0; i < run_len; i++) begin
              push_byte(window_mem[rd_pos]);
              rd_pos = rd_pos + 1'b1;
            end
            step_flag();
          end
        end
        default: ;
      endcase
      if (pending_q.size() > old_size) begin
        r = pending_q[pending_q.size() - 1];
        r.run_last = 1'b1;
        pending_q[pending_q.size() - 1] = r;
      end
    endfunction

    task check_output(input dec_result_t got);
      dec_result_t exp_r;
      string       bad;
      if (pending_q.size() == 0) begin
        report($sformatf("result %0d with nothing outstanding: byte=%h bv=%b last=%b done=%b cnt=%0d",
                         seen, got.out_byte, got.byte_valid, got.run_last, got.chunk_done,
                         got.produced_count));
      end else begin
        exp_r = pending_q[0];
        pending_q.delete(0);
        bad = "";
        if (got.out_byte !== exp_r.out_byte)             bad = {bad, " out_byte"};
        if (got.byte_valid !== exp_r.byte_valid)         bad = {bad, " byte_valid"};
        if (got.run_last !== exp_r.run_last)             bad = {bad, " run_last"};
        if (got.chunk_done !== exp_r.chunk_done)         bad = {bad, " chunk_done"};
        if (got.produced_count !== exp_r.produced_count) bad = {bad, " produced_count"};
        if (bad != "")
          report($sformatf("result %0d:%s | got %h/%b/%b/%b/%0d exp %h/%b/%b/%b/%0d", seen, bad,
                           got.out_byte, got.byte_valid, got.run_last, got.chunk_done,
                           got.produced_count, exp_r.out_byte, exp_r.byte_valid,
                           exp_r.run_last, exp_r.chunk_done, exp_r.produced_count));
      end
      seen++;
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT connections. All inputs hold known values from time 0.
  // ---------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic [7:0]  in_byte_i     = 8'h00;
  logic        chunk_start_i = 1'b0;
  logic        out_ready_i   = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic        byte_valid_o;
  logic        run_last_o;
  logic        chunk_done_o;
  logic [16:0] produced_count_o;

  lzss_scoreboard sb = new();

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  lzss_window_decompressor_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_byte_i        (in_byte_i),
    .chunk_start_i    (chunk_start_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .byte_valid_o     (byte_valid_o),
    .run_last_o       (run_last_o),
    .chunk_done_o     (chunk_done_o),
    .produced_count_o (produced_count_o)
  );

  // ---------------------------------------------------------------------------
  // Output side. The sink picks a ready pattern for a random stretch of cycles:
  // always ready, random, long ready and stalled stretches in turn, or ready one cycle in four.
  // ---------------------------------------------------------------------------
  logic [15:0] sink_pattern = 16'hFFFF;
  logic [3:0]  sink_phase   = '0;
  int unsigned sink_hold    = 0;

  always @(posedge clk_i) begin
    if (sink_hold == 0) begin
      case ($urandom_range(0, 3))
        0:       sink_pattern <= 16'hFFFF;
        1:       sink_pattern <= 16'($urandom);
        2:       sink_pattern <= 16'h00FF;
        default: sink_pattern <= 16'h1111;
      endcase
      sink_hold <= $urandom_range(30, 120);
    end else begin
      sink_hold <= sink_hold - 1;
    end
    sink_phase  <= sink_phase + 1'b1;
    out_ready_i <= sink_pattern[sink_phase];
  end

  // Output transfers are sampled at the edge, before any update of that edge lands.
  dec_result_t seen_result;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_result.out_byte       = out_byte_o;
      seen_result.byte_valid     = byte_valid_o;
      seen_result.run_last       = run_last_o;
      seen_result.chunk_done     = chunk_done_o;
      seen_result.produced_count = produced_count_o;
      sb.check_output(seen_result);
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Bytes go out in bursts of random length; between bursts valid
  // drops for a random gap. Valid stays up with a steady payload until the
  // transfer completes, and the scoreboard is told at that edge.
  // ---------------------------------------------------------------------------
  int unsigned burst_left    = 0;
  int unsigned random_items  = 0;
  logic [7:0]  tok_high_next = 8'h00;

  task automatic send_byte(input logic [7:0] b, input logic s);
    int unsigned gap;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
    in_valid_i    <= 1'b1;
    in_byte_i     <= b;
    chunk_start_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(b, s);
    burst_left--;
  endtask

  // Token layout: low byte {pos[3:0], length code}, high byte pos[11:4].
  task automatic send_token(input logic [WinAw-1:0] pos, input logic [3:0] len_code);
    send_byte({pos[3:0], len_code}, 1'b0);
    send_byte(pos[11:4], 1'b0);
  endtask

  // Picks the next byte from the parse state the scoreboard is in, so most
  // traffic is well-formed chunks; a few percent are restarts and noise.
  task automatic send_random_byte();
    logic [7:0]       b;
    logic             s;
    logic [WinAw-1:0] pos;
    int unsigned      pick;
    s    = 1'b0;
    b    = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      s = 1'b1;  // restart mid-chunk
    end else if (pick >= 6) begin
      case (sb.phase)
        PH_FLAG: ;
        PH_ITEM: begin
          if (sb.flag_bits[sb.flag_pos]) begin
            case ($urandom_range(0, 15))
              0, 1:          pos = '0;  // end of chunk
              2, 3, 4, 5, 6: pos = sb.wr_ptr - 12'($urandom_range(1, 18));  // may overlap
              default:       pos = 12'($urandom_range(1, WinDepth - 1));
            endcase
            if (pos == '0 && sb.wr_ptr <= 18 && sb.wr_ptr != 0) pos = sb.wr_ptr - 1'b1;
            tok_high_next = pos[11:4];
            b = {pos[3:0], 4'($urandom)};
          end
        end
        PH_HIGH: b = tok_high_next;
        default: if ($urandom_range(0, 2) != 0) s = 1'b1;  // else an ignored byte
      endcase
    end
    if (s || sb.phase != PH_DONE) random_items++;
    send_byte(b, s);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. No chunk start after reset: parse from reset state.
    send_byte(8'b0000_0010, 1'b0);
    send_byte(8'h00, 1'b0);
    send_token(12'hFFF, 4'hF);  // 17 cleared bytes, wrapping past the window top
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    // all tokens: shortest overlapping run, longest overlapping run, then end
    send_byte(8'hFF, 1'b0);
    send_token(sb.wr_ptr - 1'b1, 4'h0);
    send_token(sb.wr_ptr - 12'd2, 4'hF);
    send_token(12'h000, 4'h7);
    // bytes after the end token are dropped
    send_byte(8'h3C, 1'b0);
    send_byte(8'hFF, 1'b0);
    // new chunk: window kept, pointer back at 1, so position 1 reads old data
    send_byte(8'hFF, 1'b1);
    send_token(12'h001, 4'h5);
    // restart between the two halves of a token
    send_byte(8'hA7, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h12, 1'b0);
    // end token straight after a chunk start: count of zero
    send_byte(8'h01, 1'b1);
    send_token(12'h000, 4'h0);

    // Random part.
    while (random_items < RANDOM_ITEMS) send_random_byte();

    in_valid_i <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run, window clearing included.
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
